FILE: sv/qcts_pkg.sv
// Package: shared constants, codes and controller/datapath interface types.
`timescale 1ns / 1ps
`default_nettype none
package qcts_pkg;

  localparam int MAX_VECTORS = 256;
  localparam int MAX_DIM     = 1024;
  localparam int MAX_TOP_K   = 16;

  localparam int VEC_AW   = $clog2(MAX_VECTORS);
  localparam int DIM_AW   = $clog2(MAX_DIM);
  localparam int TK_AW    = $clog2(MAX_TOP_K);
  localparam int CNT_W    = $clog2(MAX_VECTORS + 1);
  localparam int POS_W    = 11;
  localparam int LEN_W    = 11;
  localparam int K_W      = 5;
  localparam int ELEM_W   = 16;
  localparam int CODE_W   = 8;
  localparam int SUM_W    = 40;
  localparam int RAD_W    = 48;
  localparam int NORM_W   = 24;
  localparam int SQR_W    = 28;
  localparam int PROD_W   = 27;
  localparam int DOT_W    = 36;
  localparam int MAG_W    = 35;
  localparam int DEN_W    = 56;
  localparam int REM_W    = 58;
  localparam int Q_W      = 14;
  localparam int SCORE_W  = 16;
  localparam int STS_W    = 3;

  localparam int SQ_STEPS  = NORM_W;
  localparam int DIV_STEPS = Q_W;

  localparam logic [LEN_W-1:0] VLEN_RESET = 11'd768;

  // Result status codes
  typedef enum logic [STS_W-1:0] {
    STS_APPENDED = 3'd0,
    STS_MATCH    = 3'd1,
    STS_LEN_ERR  = 3'd2,
    STS_FULL     = 3'd3,
    STS_EMPTY    = 3'd4
  } status_t;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_SQRT,
    S_APPEND,
    S_COMMIT,
    S_DOT,
    S_DRAIN,
    S_MUL,
    S_DLOAD,
    S_DIV,
    S_SCORE,
    S_INSERT,
    S_EMIT,
    S_RESP
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic    beat;
    logic    prep;
    logic    sqrt_step;
    logic    app_rd;
    logic    commit;
    logic    dot_rd;
    logic    mul;
    logic    dload;
    logic    div_step;
    logic    score;
    logic    insert;
    logic    emit;
    logic    resp;
    status_t resp_code;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic len_ok;
    logic is_query;
    logic full;
    logic empty;
    logic kzero;
    logic sqrt_last;
    logic app_last;
    logic dot_last;
    logic busy;
    logic div_last;
    logic last_entry;
    logic emit_last;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

FILE: sv/qcts_ctrl.sv
// Controller: sequences beats, norm, append, scan, ranking and result output.
`timescale 1ns / 1ps
`default_nettype none
module qcts_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          in_last_element,
  input  wire qcts_pkg::sts_t sts,
  output qcts_pkg::cmd_t     cmd,
  output logic               in_ready
);
  import qcts_pkg::*;

  state_t  state_r, state_nxt;
  status_t code_r, code_nxt;

  // State and pending response code
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      code_r  <= STS_APPENDED;
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    code_nxt  = code_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_last_element) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (!sts.len_ok) begin
          state_nxt = S_RESP;
          code_nxt  = STS_LEN_ERR;
        end else if (!sts.is_query) begin
          if (sts.full) begin
            state_nxt = S_RESP;
            code_nxt  = STS_FULL;
          end else begin
            state_nxt = S_SQRT;
          end
        end else if (sts.empty || sts.kzero) begin
          state_nxt = S_RESP;
          code_nxt  = STS_EMPTY;
        end else begin
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        if (sts.sqrt_last) state_nxt = sts.is_query ? S_DOT : S_APPEND;
      end
      S_APPEND: begin
        if (sts.app_last) state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        state_nxt = S_RESP;
        code_nxt  = STS_APPENDED;
      end
      S_DOT: begin
        if (sts.dot_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (!sts.busy) state_nxt = S_MUL;
      end
      S_MUL:   state_nxt = S_DLOAD;
      S_DLOAD: state_nxt = S_DIV;
      S_DIV: begin
        if (sts.div_last) state_nxt = S_SCORE;
      end
      S_SCORE: state_nxt = S_INSERT;
      S_INSERT: begin
        state_nxt = sts.last_entry ? S_EMIT : S_DOT;
      end
      S_EMIT: begin
        if (sts.out_free && sts.emit_last) state_nxt = S_IDLE;
      end
      S_RESP: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd           = '0;
    cmd.resp_code = code_r;
    in_ready      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.beat = in_valid;
      end
      S_CHECK:  cmd.prep      = 1'b1;
      S_SQRT:   cmd.sqrt_step = 1'b1;
      S_APPEND: cmd.app_rd    = 1'b1;
      S_COMMIT: cmd.commit    = 1'b1;
      S_DOT:    cmd.dot_rd    = 1'b1;
      S_DRAIN:  cmd.dot_rd    = 1'b0;
      S_MUL:    cmd.mul       = 1'b1;
      S_DLOAD:  cmd.dload     = 1'b1;
      S_DIV:    cmd.div_step  = 1'b1;
      S_SCORE:  cmd.score     = 1'b1;
      S_INSERT: cmd.insert    = 1'b1;
      S_EMIT:   cmd.emit      = sts.out_free;
      S_RESP:   cmd.resp      = sts.out_free;
      default:  cmd.beat      = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

FILE: sv/qcts_dp.sv
// Datapath: element buffer, code/norm stores, sqrt, dot product, divider, top-k list.
`timescale 1ns / 1ps
`default_nettype none
module qcts_dp (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire qcts_pkg::cmd_t                  cmd,
  output qcts_pkg::sts_t                       sts,
  input  wire logic                            cfg_valid,
  input  wire logic [qcts_pkg::LEN_W-1:0]      cfg_data,
  input  wire logic                            in_action,
  input  wire logic signed [qcts_pkg::ELEM_W-1:0] in_element_value,
  input  wire logic                            in_last_element,
  input  wire logic [qcts_pkg::K_W-1:0]        in_top_k,
  input  wire logic                            out_ready,
  output logic                                 out_valid,
  output logic [qcts_pkg::STS_W-1:0]           out_status,
  output logic [qcts_pkg::VEC_AW-1:0]          out_entry_index,
  output logic signed [qcts_pkg::SCORE_W-1:0]  out_score,
  output logic                                 out_last_result
);
  import qcts_pkg::*;

  // Memories
  logic signed [ELEM_W-1:0] qbuf_mem [MAX_DIM];
  logic [CODE_W-1:0]        code_mem [MAX_VECTORS*MAX_DIM];
  logic [NORM_W-1:0]        norm_mem [MAX_VECTORS];

  // Control and accumulation registers
  logic [LEN_W-1:0]  vlen_r;
  logic [POS_W-1:0]  pos_r;
  logic [SUM_W-1:0]  sum_r;
  logic              act_r, len_ok_r;
  logic [K_W-1:0]    k_r, kk_r;
  logic [CNT_W-1:0]  count_r;
  logic [POS_W-1:0]  j_r;
  logic [CNT_W-1:0]  i_r;
  logic [K_W-1:0]    n_r, e_r;

  // Sqrt unit
  logic [RAD_W-1:0]  rad_r;
  logic [SQR_W-1:0]  sq_rem_r;
  logic [NORM_W-1:0] root_r;
  logic [4:0]        sq_cnt_r;

  // Read and dot pipeline
  logic signed [ELEM_W-1:0] qrd_r;
  logic [CODE_W-1:0]        crd_r;
  logic [NORM_W-1:0]        nd_r;
  logic                     awv_r, dv1_r, dv2_r;
  logic [DIM_AW-1:0]        awj_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [DOT_W-1:0]  acc_r;

  // Divider
  logic [2*NORM_W-1:0] prd_r;
  logic [MAG_W-1:0]    mag_r;
  logic                neg_r, zero_r, sat_r;
  logic [DEN_W-1:0]    den_r;
  logic [REM_W-1:0]    div_rem_r;
  logic [Q_W-1:0]      q_r;
  logic [3:0]          div_cnt_r;
  logic signed [SCORE_W-1:0] score_r;

  // Best list
  logic signed [SCORE_W-1:0] bs_r [MAX_TOP_K];
  logic [VEC_AW-1:0]         bi_r [MAX_TOP_K];

  // Element beat arithmetic
  logic signed [2*ELEM_W-1:0] sq_prod;
  logic [SUM_W:0]             sum_add;
  logic [SUM_W-1:0]           sum_sat;
  logic [POS_W-1:0]           pos_inc;
  logic                       len_ok_now;

  assign sq_prod = in_element_value * in_element_value;
  assign sum_add = {1'b0, sum_r} + {{(SUM_W+1-2*ELEM_W){1'b0}}, sq_prod};
  assign sum_sat = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
  assign pos_inc = (pos_r < POS_W'(MAX_DIM + 1)) ? pos_r + POS_W'(1) : pos_r;
  assign len_ok_now = (vlen_r >= LEN_W'(1)) && (vlen_r <= LEN_W'(MAX_DIM)) &&
                      (pos_inc == vlen_r);

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vlen_r <= VLEN_RESET;
    end else if (cfg_valid) begin
      vlen_r <= cfg_data;
    end
  end

  // Beat accumulation and end-of-vector capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      sum_r <= '0;
    end else if (cmd.beat) begin
      if (in_last_element) begin
        pos_r <= '0;
        sum_r <= '0;
      end else begin
        pos_r <= pos_inc;
        sum_r <= sum_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.beat && in_last_element) begin
      act_r    <= in_action;
      k_r      <= in_top_k;
      len_ok_r <= len_ok_now;
    end
  end

  // Query buffer write and registered read
  always_ff @(posedge clk) begin
    if (cmd.beat && (pos_r < POS_W'(MAX_DIM))) qbuf_mem[pos_r[DIM_AW-1:0]] <= in_element_value;
    qrd_r <= qbuf_mem[j_r[DIM_AW-1:0]];
  end

  // Integer square root, two radicand bits per step
  logic [SQR_W-1:0] rem_sh, trial;
  assign rem_sh = {sq_rem_r[SQR_W-3:0], rad_r[RAD_W-1:RAD_W-2]};
  assign trial  = {2'b00, root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (cmd.beat && in_last_element) begin
      rad_r    <= {sum_sat, 8'h00};
      sq_rem_r <= '0;
      root_r   <= '0;
      sq_cnt_r <= '0;
    end else if (cmd.sqrt_step) begin
      rad_r    <= {rad_r[RAD_W-3:0], 2'b00};
      sq_cnt_r <= sq_cnt_r + 5'd1;
      if (rem_sh >= trial) begin
        sq_rem_r <= rem_sh - trial;
        root_r   <= {root_r[NORM_W-2:0], 1'b1};
      end else begin
        sq_rem_r <= rem_sh;
        root_r   <= {root_r[NORM_W-2:0], 1'b0};
      end
    end
  end

  // Quantizer on the registered buffer read
  logic signed [ELEM_W-1:0] clamped, shifted;
  logic [14:0]              qu;
  logic [22:0]              scaled;
  logic [CODE_W-1:0]        qcode;

  always_comb begin
    if (qrd_r < -16'sd8192)     clamped = -16'sd8192;
    else if (qrd_r > 16'sd8192) clamped = 16'sd8192;
    else                        clamped = qrd_r;
    shifted = clamped + 16'sd8192;
    qu      = shifted[14:0];
    scaled  = {qu, 8'h00} - {8'h00, qu};
    qcode   = scaled[21:14];
  end

  // Code store: append writes, scan reads
  always_ff @(posedge clk) begin
    if (awv_r) code_mem[{count_r[VEC_AW-1:0], awj_r}] <= qcode;
    crd_r <= code_mem[{i_r[VEC_AW-1:0], j_r[DIM_AW-1:0]}];
  end

  // Norm store
  always_ff @(posedge clk) begin
    if (cmd.commit) norm_mem[count_r[VEC_AW-1:0]] <= root_r;
    nd_r <= norm_mem[i_r[VEC_AW-1:0]];
  end

  // Entry counter and read pipeline flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      awv_r   <= 1'b0;
      dv1_r   <= 1'b0;
      dv2_r   <= 1'b0;
    end else begin
      awv_r <= cmd.app_rd;
      dv1_r <= cmd.dot_rd;
      dv2_r <= dv1_r;
      if (cmd.commit) count_r <= count_r + CNT_W'(1);
    end
  end

  logic [K_W-1:0] k_clip;
  assign k_clip = (k_r > K_W'(MAX_TOP_K)) ? K_W'(MAX_TOP_K) : k_r;

  always_ff @(posedge clk) begin
    awj_r <= j_r[DIM_AW-1:0];
    if (cmd.prep) begin
      j_r  <= '0;
      i_r  <= '0;
      e_r  <= '0;
      kk_r <= ({{(CNT_W-K_W){1'b0}}, k_clip} > count_r) ? count_r[K_W-1:0] : k_clip;
    end else if (cmd.app_rd || cmd.dot_rd) begin
      j_r <= j_r + POS_W'(1);
    end else if (cmd.insert) begin
      j_r <= '0;
      i_r <= i_r + CNT_W'(1);
    end else if (cmd.emit) begin
      e_r <= e_r + K_W'(1);
    end
  end

  // Dot product: multiply stage then accumulate stage
  logic signed [10:0] dq;
  assign dq = $signed({1'b0, crd_r, 2'b00}) - 11'sd510;

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(qrd_r) * PROD_W'(dq);
    if (cmd.prep || cmd.insert) acc_r <= '0;
    else if (dv2_r)             acc_r <= acc_r + {{(DOT_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
  end

  // Divider setup and bit-serial quotient
  logic [DOT_W-1:0] acc_abs;
  logic [REM_W-1:0] div_sh, den_x;
  assign acc_abs = acc_r[DOT_W-1] ? DOT_W'(-acc_r) : DOT_W'(acc_r);
  assign div_sh  = {div_rem_r[REM_W-2:0], 1'b0};
  assign den_x   = {2'b00, den_r};

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prd_r  <= root_r * nd_r;
      mag_r  <= acc_abs[MAG_W-1:0];
      neg_r  <= acc_r[DOT_W-1];
      zero_r <= (root_r == '0) || (nd_r == '0);
    end
    if (cmd.dload) begin
      den_r     <= {prd_r, 8'h00} - {8'h00, prd_r};
      div_rem_r <= {3'b000, mag_r, 20'h00000};
      q_r       <= '0;
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      div_cnt_r <= div_cnt_r + 4'd1;
      if (div_cnt_r == 4'd0) begin
        sat_r <= div_rem_r >= den_x;
      end else if (div_sh >= den_x) begin
        div_rem_r <= div_sh - den_x;
        q_r       <= {q_r[Q_W-2:0], 1'b1};
      end else begin
        div_rem_r <= div_sh;
        q_r       <= {q_r[Q_W-2:0], 1'b0};
      end
    end
  end

  // Signed, saturated score
  logic [SCORE_W-1:0] score_mag;
  always_comb begin
    if (zero_r)     score_mag = '0;
    else if (sat_r) score_mag = SCORE_W'(16384);
    else            score_mag = {2'b00, q_r};
  end

  always_ff @(posedge clk) begin
    if (cmd.score) score_r <= neg_r ? $signed(-score_mag) : $signed(score_mag);
  end

  // Top-k insertion: ge marks kept entries above the new one
  logic [MAX_TOP_K-1:0] ge;
  logic [K_W-1:0]       kk_m1, lim;
  logic                 doins;

  always_comb begin
    for (int m = 0; m < MAX_TOP_K; m++) begin
      ge[m] = (K_W'(m) < n_r) && (bs_r[m] >= score_r);
    end
    kk_m1 = kk_r - K_W'(1);
    doins = !ge[kk_m1[TK_AW-1:0]];
    lim   = (n_r < kk_r) ? n_r : kk_m1;
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      n_r <= '0;
    end else if (cmd.insert && doins && (n_r < kk_r)) begin
      n_r <= n_r + K_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert && doins) begin
      if (!ge[0]) begin
        bs_r[0] <= score_r;
        bi_r[0] <= i_r[VEC_AW-1:0];
      end
      for (int m = 1; m < MAX_TOP_K; m++) begin
        if (K_W'(m) <= lim && !ge[m]) begin
          if (ge[m-1]) begin
            bs_r[m] <= score_r;
            bi_r[m] <= i_r[VEC_AW-1:0];
          end else begin
            bs_r[m] <= bs_r[m-1];
            bi_r[m] <= bi_r[m-1];
          end
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.emit || cmd.resp) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status      <= STS_MATCH;
      out_entry_index <= bi_r[e_r[TK_AW-1:0]];
      out_score       <= bs_r[e_r[TK_AW-1:0]];
      out_last_result <= (e_r == n_r - K_W'(1));
    end else if (cmd.resp) begin
      out_status      <= cmd.resp_code;
      out_entry_index <= '0;
      out_score       <= '0;
      out_last_result <= 1'b1;
    end
  end

  // Status to controller
  always_comb begin
    sts.len_ok     = len_ok_r;
    sts.is_query   = act_r;
    sts.full       = count_r >= CNT_W'(MAX_VECTORS);
    sts.empty      = count_r == '0;
    sts.kzero      = k_r == '0;
    sts.sqrt_last  = sq_cnt_r == 5'(SQ_STEPS - 1);
    sts.app_last   = j_r == vlen_r - LEN_W'(1);
    sts.dot_last   = j_r == vlen_r - LEN_W'(1);
    sts.busy       = dv1_r || dv2_r;
    sts.div_last   = div_cnt_r == 4'(DIV_STEPS);
    sts.last_entry = i_r == count_r - CNT_W'(1);
    sts.emit_last  = e_r == n_r - K_W'(1);
    sts.out_free   = !out_valid || out_ready;
  end

endmodule
`default_nettype wire

FILE: sv/quantized_cosine_top_k_search.sv
// Top level: quantized cosine top-k search, controller plus datapath.
//
//   channel  direction  handshake           payload
//   cfg      in         cfg_valid/cfg_ready  cfg_data (vector_length)
//   in       in         in_valid/in_ready    in_action, in_element_value,
//                                            in_last_element, in_top_k
//   out      out        out_valid/out_ready  out_status, out_entry_index,
//                                            out_score, out_last_result
//
// A final beat with an error goes straight from the check state to the response state.
// A final append beat runs a 24-step square root, then one code write a cycle.
// A final query beat does, for each stored entry, one code read per element, a drain
// of the read pipeline and a bit-serial divider, then emits the results, best first.
// Synchronous active-low reset; stored vectors are undefined until written.
// in_ready drops while a vector is finished; results stall on out_ready.
`timescale 1ns / 1ps
`default_nettype none
module quantized_cosine_top_k_search (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [qcts_pkg::LEN_W-1:0]         cfg_data,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic                               in_action,
  input  wire logic signed [qcts_pkg::ELEM_W-1:0] in_element_value,
  input  wire logic                               in_last_element,
  input  wire logic [qcts_pkg::K_W-1:0]           in_top_k,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [qcts_pkg::STS_W-1:0]              out_status,
  output logic [qcts_pkg::VEC_AW-1:0]             out_entry_index,
  output logic signed [qcts_pkg::SCORE_W-1:0]     out_score,
  output logic                                    out_last_result
);
  import qcts_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  // Sequencer
  qcts_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_last_element (in_last_element),
    .sts             (sts),
    .cmd             (cmd),
    .in_ready        (in_ready)
  );

  // Datapath
  qcts_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_valid        (cfg_valid),
    .cfg_data         (cfg_data),
    .in_action        (in_action),
    .in_element_value (in_element_value),
    .in_last_element  (in_last_element),
    .in_top_k         (in_top_k),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_entry_index  (out_entry_index),
    .out_score        (out_score),
    .out_last_result  (out_last_result)
  );

endmodule
`default_nettype wire
